// ===== rtl/date_to_day_number_core_macros.svh =====
// Assertion macros shared by the date-to-day-number checker.
// Standalone header; needs no other file.
`ifndef DATE_TO_DAY_NUMBER_CORE_MACROS_SVH
`define DATE_TO_DAY_NUMBER_CORE_MACROS_SVH

// Check that a condition implies another at the same edge.
`define D2DN_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("date_to_day_number_core: implication check failed");

// Check that a condition implies another at the next edge.
`define D2DN_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("date_to_day_number_core: next-cycle check failed");

`endif

// ===== rtl/d2dn_pkg.sv =====
// Shared types, constants and calendar tables for the date-to-day-number core.
// No dependencies.
`timescale 1ns / 1ps

package d2dn_pkg;

    localparam int DATE_W   = 27;
    localparam int COUNT_W  = 22;
    localparam int CODE_W   = 3;
    localparam int VALUE_W  = 7;
    localparam int YEAR_W   = 14;

    // Reciprocal constants for exact division by 10000 and by 100
    localparam int                 DIV625_SHIFT = 33;
    localparam logic [23:0]        DIV625_MUL   = 24'd13743896;
    localparam int                 DIV25_SHIFT  = 17;
    localparam logic [12:0]        DIV25_MUL    = 13'd5243;

    localparam logic [VALUE_W-1:0] VALUE_MAX    = 7'd99;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_NOT_POS  = 3'd1,
        ERR_YEAR     = 3'd2,
        ERR_MONTH    = 3'd3,
        ERR_DAY      = 3'd4
    } t_err;

    // Days in a month (1..12); February depends on leap
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                        len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month (1..12)
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] dbm;
        case (month)
            4'd1:    dbm = 9'd0;
            4'd2:    dbm = 9'd31;
            4'd3:    dbm = 9'd59;
            4'd4:    dbm = 9'd90;
            4'd5:    dbm = 9'd120;
            4'd6:    dbm = 9'd151;
            4'd7:    dbm = 9'd181;
            4'd8:    dbm = 9'd212;
            4'd9:    dbm = 9'd243;
            4'd10:   dbm = 9'd273;
            4'd11:   dbm = 9'd304;
            4'd12:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

// ===== rtl/date_to_day_number_core.sv =====
// Throughput one item per cycle while the output is not stalled (i_stall low).
// Five register stages: split by 10000, split by 100, year quotients, checks, final sum.
// Each stage holds only while its own result is blocked, so bubbles are squeezed out.
// Reset (synchronous, active low) clears the stage valid bits; payload is not reset.
// Depends on d2dn_pkg.
`timescale 1ns / 1ps

module date_to_day_number_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [d2dn_pkg::DATE_W-1:0]        i_date_number,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [d2dn_pkg::COUNT_W-1:0]       o_day_count,
    output logic [d2dn_pkg::CODE_W-1:0]        o_error_code,
    output logic [d2dn_pkg::VALUE_W-1:0]       o_error_value
);

    // Stage valids and per-stage advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5     = !r_v5 || !i_stall;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // Stage 1: reciprocal product for date / 10000
    logic [d2dn_pkg::DATE_W-1:0]     r_s1_d;
    logic [46:0]                     r_s1_prod, n_s1_prod;
    logic                            r_s1_zero;

    assign n_s1_prod = 47'(i_date_number[26:4]) * 47'(d2dn_pkg::DIV625_MUL);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_d    <= i_date_number;
            r_s1_prod <= n_s1_prod;
            r_s1_zero <= (i_date_number == '0);
        end
    end

    // Stage 2: year digits and reciprocal product for (date / 10000) / 100
    logic [13:0]                     q1;
    logic [d2dn_pkg::DATE_W-1:0]     q1_scaled;
    logic [d2dn_pkg::YEAR_W-1:0]     r_s2_year, n_s2_year;
    logic [13:0]                     r_s2_q1;
    logic [24:0]                     r_s2_prod, n_s2_prod;
    logic                            r_s2_zero;

    assign q1        = r_s1_prod[46:33];
    assign q1_scaled = d2dn_pkg::DATE_W'(q1) * d2dn_pkg::DATE_W'(10000);
    assign n_s2_year = d2dn_pkg::YEAR_W'(r_s1_d - q1_scaled);
    assign n_s2_prod = 25'(q1[13:2]) * 25'(d2dn_pkg::DIV25_MUL);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_year <= n_s2_year;
            r_s2_q1   <= q1;
            r_s2_prod <= n_s2_prod;
            r_s2_zero <= r_s1_zero;
        end
    end

    // Stage 3: day and month digits, year quotient products, y1 * 365
    logic [7:0]                      day3;
    logic [13:0]                     month_full;
    logic [d2dn_pkg::YEAR_W-1:0]     y1;
    logic [7:0]                      r_s3_day;
    logic [6:0]                      r_s3_month;
    logic [d2dn_pkg::YEAR_W-1:0]     r_s3_year, r_s3_y1;
    logic [24:0]                     r_s3_ycp, n_s3_ycp, r_s3_y1cp, n_s3_y1cp;
    logic [d2dn_pkg::COUNT_W-1:0]    r_s3_y365, n_s3_y365;
    logic                            r_s3_zero;

    assign day3       = r_s2_prod[24:17];
    assign month_full = r_s2_q1 - (14'(day3) * 14'd100);
    assign y1         = r_s2_year - 14'd1;
    assign n_s3_ycp   = 25'(r_s2_year[13:2]) * 25'(d2dn_pkg::DIV25_MUL);
    assign n_s3_y1cp  = 25'(y1[13:2]) * 25'(d2dn_pkg::DIV25_MUL);
    assign n_s3_y365  = d2dn_pkg::COUNT_W'(y1) * 22'd365;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_day   <= day3;
            r_s3_month <= month_full[6:0];
            r_s3_year  <= r_s2_year;
            r_s3_y1    <= y1;
            r_s3_ycp   <= n_s3_ycp;
            r_s3_y1cp  <= n_s3_y1cp;
            r_s3_y365  <= n_s3_y365;
            r_s3_zero  <= r_s2_zero;
        end
    end

    // Stage 4: leap rule, field checks, year part of the count
    logic [6:0]                      yc;
    logic [7:0]                      y1c;
    logic                            hundred, leap;
    logic [4:0]                      maxday;
    d2dn_pkg::t_err                  n_s4_code;
    logic [d2dn_pkg::VALUE_W-1:0]    n_s4_val;
    logic [d2dn_pkg::COUNT_W-1:0]    n_s4_base;
    d2dn_pkg::t_err                  r_s4_code;
    logic [d2dn_pkg::VALUE_W-1:0]    r_s4_val;
    logic [d2dn_pkg::COUNT_W-1:0]    r_s4_base;
    logic [3:0]                      r_s4_month;
    logic [4:0]                      r_s4_day;
    logic                            r_s4_leap;

    assign yc        = r_s3_ycp[23:17];
    assign y1c       = r_s3_y1cp[24:17];
    assign hundred   = (r_s3_year == (14'(yc) * 14'd100));
    assign leap      = (r_s3_year[1:0] == 2'd0) && (!hundred || (yc[1:0] == 2'd0));
    assign maxday    = d2dn_pkg::month_len(r_s3_month[3:0], leap);
    assign n_s4_base = r_s3_y365 + d2dn_pkg::COUNT_W'(r_s3_y1[13:2])
                     - d2dn_pkg::COUNT_W'(y1c) + d2dn_pkg::COUNT_W'(y1c[7:2]);

    // Pick the first failing check
    always_comb begin
        n_s4_code = d2dn_pkg::ERR_NONE;
        n_s4_val  = '0;
        if (r_s3_zero) begin
            n_s4_code = d2dn_pkg::ERR_NOT_POS;
        end else if (r_s3_year == '0) begin
            n_s4_code = d2dn_pkg::ERR_YEAR;
        end else if (r_s3_month < 7'd1 || r_s3_month > 7'd12) begin
            n_s4_code = d2dn_pkg::ERR_MONTH;
            n_s4_val  = r_s3_month;
        end else if (r_s3_day < 8'd1 || r_s3_day > 8'(maxday)) begin
            n_s4_code = d2dn_pkg::ERR_DAY;
            n_s4_val  = (r_s3_day > 8'(d2dn_pkg::VALUE_MAX)) ? d2dn_pkg::VALUE_MAX
                                                              : r_s3_day[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_code  <= n_s4_code;
            r_s4_val   <= n_s4_val;
            r_s4_base  <= n_s4_base;
            r_s4_month <= r_s3_month[3:0];
            r_s4_day   <= r_s3_day[4:0];
            r_s4_leap  <= leap;
        end
    end

    // Stage 5: add month offset, leap day and day; zero the count on error
    logic [d2dn_pkg::COUNT_W-1:0]    n_s5_count, r_s5_count;
    logic [d2dn_pkg::CODE_W-1:0]     r_s5_code;
    logic [d2dn_pkg::VALUE_W-1:0]    r_s5_val;
    logic                            leap_add;

    assign leap_add   = r_s4_leap && (r_s4_month > 4'd2);
    assign n_s5_count = (r_s4_code != d2dn_pkg::ERR_NONE) ? '0 :
                        r_s4_base + d2dn_pkg::COUNT_W'(d2dn_pkg::days_before(r_s4_month))
                        + d2dn_pkg::COUNT_W'(leap_add) + d2dn_pkg::COUNT_W'(r_s4_day);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_count <= n_s5_count;
            r_s5_code  <= r_s4_code;
            r_s5_val   <= r_s4_val;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    assign o_valid       = r_v5;
    assign o_day_count   = r_s5_count;
    assign o_error_code  = r_s5_code;
    assign o_error_value = r_s5_val;

endmodule

// ===== rtl/d2dn_checker.sv =====
// Port-level checks for the date-to-day-number core, bound to the top level.
// Depends on d2dn_pkg and date_to_day_number_core_macros.svh.
`timescale 1ns / 1ps
`include "date_to_day_number_core_macros.svh"

module d2dn_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [d2dn_pkg::DATE_W-1:0]        i_date_number,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [d2dn_pkg::COUNT_W-1:0]       o_day_count,
    input logic [d2dn_pkg::CODE_W-1:0]        o_error_code,
    input logic [d2dn_pkg::VALUE_W-1:0]       o_error_value
);

    logic out_ok, out_err, out_zero_val, out_wait, in_wait;
    logic [d2dn_pkg::COUNT_W+d2dn_pkg::CODE_W+d2dn_pkg::VALUE_W-1:0] out_item;

    // Classify the result on the output
    assign out_ok       = o_valid && (o_error_code == d2dn_pkg::ERR_NONE);
    assign out_err      = o_valid && (o_error_code != d2dn_pkg::ERR_NONE);
    assign out_zero_val = o_valid && (o_error_code == d2dn_pkg::ERR_NOT_POS ||
                                      o_error_code == d2dn_pkg::ERR_YEAR);
    assign out_wait     = o_valid && i_stall;
    assign in_wait      = i_valid && o_stall;
    assign out_item     = {o_day_count, o_error_code, o_error_value};

    // A valid date never maps to day zero, an error always does
    `D2DN_ASSERT_IMPLY(a_ok_count, i_clk, i_rst_n, out_ok, o_day_count != '0 && o_error_value == '0)
    `D2DN_ASSERT_IMPLY(a_err_count, i_clk, i_rst_n, out_err, o_day_count == '0)
    // Zero input and year zero both report value zero
    `D2DN_ASSERT_IMPLY(a_zero_val, i_clk, i_rst_n, out_zero_val, o_error_value == '0)
    // A stalled result holds
    `D2DN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(out_item))
    // A stalled input item holds
    `D2DN_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_valid && $stable(i_date_number))

endmodule

bind date_to_day_number_core d2dn_checker u_d2dn_checker (.*);
